@@ rtl/ucc_pkg.sv @@
// Package for the Unix time and calendar converter.
// Holds field widths, calendar constants, the operation code and the leap and
// month-length helpers. It depends on nothing.
package ucc_pkg;

  localparam int SECS_W  = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int REM_W   = 17;
  localparam int MOD25_W = 5;
  localparam int YLEN_W  = 9;
  localparam int RCP_W   = 26;
  localparam int MUL_W   = SECS_W + RCP_W;

  typedef enum logic {
    OP_DATE_TO_SECS = 1'b0,
    OP_SECS_TO_DATE = 1'b1
  } op_t;

  localparam logic [YEAR_W-1:0]  EPOCH_YEAR     = 12'd1970;
  localparam logic [MOD25_W-1:0] EPOCH_MOD25    = 5'd20;
  localparam logic [MOD25_W-1:0] MOD25_LAST     = 5'd24;
  localparam logic [REM_W-1:0]   SECS_PER_DAY   = 17'd86400;
  localparam logic [REM_W-1:0]   SECS_PER_HOUR  = 17'd3600;
  localparam logic [REM_W-1:0]   SECS_PER_MIN   = 17'd60;
  localparam logic [RCP_W-1:0]   LEAP_DIVISOR   = 26'd25;
  localparam logic [YLEN_W-1:0]  YEAR_DAYS      = 9'd365;
  localparam logic [YLEN_W-1:0]  LEAP_YEAR_DAYS = 9'd366;
  localparam logic [MONTH_W-1:0] MONTH_FIRST    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST     = 4'd12;

  // A quotient is ((x >> PRE) * RECIP) >> SHIFT, which is exact over the range
  // of x that each division sees.
  localparam int DAY_PRE    = 7;
  localparam int DAY_SHIFT  = 35;
  localparam int HOUR_PRE   = 4;
  localparam int HOUR_SHIFT = 21;
  localparam int MIN_PRE    = 2;
  localparam int MIN_SHIFT  = 14;
  localparam int YEAR_SHIFT = 15;
  localparam logic [RCP_W-1:0] DAY_RECIP  = 26'd50903317;
  localparam logic [RCP_W-1:0] HOUR_RECIP = 26'd9321;
  localparam logic [RCP_W-1:0] MIN_RECIP  = 26'd1093;
  localparam logic [RCP_W-1:0] YEAR_RECIP = 26'd1311;

  // A year is a leap year when it divides by 4 and either does not divide by
  // 25 or divides by 16, which matches the 4, 100 and 400 rule.
  function automatic logic is_leap(input logic [3:0] year_lo,
                                   input logic [MOD25_W-1:0] mod25);
    is_leap = (year_lo[1:0] == 2'd0) && ((mod25 != '0) || (year_lo == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = leap ? 5'd29 : 5'd28;
      default:                                   d = 5'd0;
    endcase
    month_days = d;
  endfunction

endpackage

@@ rtl/ucc_in_if.sv @@
// Input channel of the Unix time and calendar converter.
// Carries valid, ready and one item; widths come from ucc_pkg.
interface ucc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ucc_pkg::YEAR_W-1:0]    in_year;
  logic [ucc_pkg::MONTH_W-1:0]   in_month;
  logic [ucc_pkg::DAY_W-1:0]     in_day;
  logic [ucc_pkg::HOUR_W-1:0]    in_hour;
  logic [ucc_pkg::MIN_W-1:0]     in_minute;
  logic [ucc_pkg::SEC_W-1:0]     in_second;
  logic [ucc_pkg::SECS_W-1:0]    in_epoch_seconds;

  modport source (output valid, operation, in_year, in_month, in_day, in_hour,
                  in_minute, in_second, in_epoch_seconds, input ready);
  modport sink   (input valid, operation, in_year, in_month, in_day, in_hour,
                  in_minute, in_second, in_epoch_seconds, output ready);
endinterface

@@ rtl/ucc_out_if.sv @@
// Result channel of the Unix time and calendar converter.
// Carries valid, ready and one result item; widths come from ucc_pkg.
interface ucc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ucc_pkg::SECS_W-1:0]    out_epoch_seconds;
  logic [ucc_pkg::YEAR_W-1:0]    out_year;
  logic [ucc_pkg::MONTH_W-1:0]   out_month;
  logic [ucc_pkg::DAY_W-1:0]     out_day;
  logic [ucc_pkg::HOUR_W-1:0]    out_hour;
  logic [ucc_pkg::MIN_W-1:0]     out_minute;
  logic [ucc_pkg::SEC_W-1:0]     out_second;

  modport source (output valid, out_epoch_seconds, out_year, out_month, out_day,
                  out_hour, out_minute, out_second, input ready);
  modport sink   (input valid, out_epoch_seconds, out_year, out_month, out_day,
                  out_hour, out_minute, out_second, output ready);
endinterface

@@ rtl/ucc_alu.sv @@
// Shared 32-bit adder and subtractor of the converter.
// Every walk, division remainder and accumulation goes through it; uses ucc_pkg.
module ucc_alu (
  input  logic [ucc_pkg::SECS_W-1:0] a,
  input  logic [ucc_pkg::SECS_W-1:0] b,
  input  logic                       sub,
  output logic [ucc_pkg::SECS_W-1:0] result,
  output logic                       carry
);
  import ucc_pkg::*;

  logic [SECS_W:0] sum;

  // For a subtraction the carry is high when a is not below b.
  assign sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{SECS_W{1'b0}}, sub};
  assign result = sum[SECS_W-1:0];
  assign carry  = sum[SECS_W];
endmodule

@@ rtl/unix_time_calendar_converter.sv @@
// Top level of the Unix time and calendar converter.
// Uses ucc_pkg, ucc_in_if, ucc_out_if and the shared adder ucc_alu.
//
//  channel | direction | payload
//  in_ch   | in        | operation, date and time of day, epoch seconds
//  out_ch  | out       | epoch seconds, date and time of day
//
// Date to seconds walks the years from 1970 and then the months before the
// given month, adding their lengths in days.
// Seconds to date takes reciprocal divisions for days, hours and minutes, each
// a quotient, product and remainder step, then walks the years and the months.
// All of it runs through one shared adder and one multiplier under the sequencer.
// Reset is synchronous and clears the sequencer and the result valid only.
// A finished result waits in the output register; the next item is taken
// while it stalls, and a second result waits until the first is taken.
module unix_time_calendar_converter (
  input  logic      clk,
  input  logic      rst_n,
  ucc_in_if.sink    in_ch,
  ucc_out_if.source out_ch
);
  import ucc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D_QYR,
    ST_D_PYR,
    ST_D_RYR,
    ST_D_YEAR,
    ST_D_MONTH,
    ST_D_DAY,
    ST_D_DAYM1,
    ST_D_MULDAY,
    ST_D_MULHR,
    ST_D_ADDHR,
    ST_D_MULMIN,
    ST_D_ADDMIN,
    ST_D_ADDSEC,
    ST_S_QDAY,
    ST_S_PDAY,
    ST_S_RDAY,
    ST_S_QHR,
    ST_S_PHR,
    ST_S_RHR,
    ST_S_QMIN,
    ST_S_PMIN,
    ST_S_RMIN,
    ST_S_YEAR,
    ST_S_MONTH,
    ST_FIN
  } state_t;

  state_t               state_r;
  op_t                  op_r;
  logic [YEAR_W-1:0]    year_in_r;
  logic [MONTH_W-1:0]   month_in_r;
  logic [DAY_W-1:0]     day_in_r;
  logic [HOUR_W-1:0]    hour_in_r;
  logic [MIN_W-1:0]     min_in_r;
  logic [SEC_W-1:0]     sec_in_r;
  logic [SECS_W-1:0]    acc_r;
  logic [SECS_W-1:0]    num_r;
  logic [SECS_W-1:0]    prod_r;
  logic [REM_W-1:0]     rem_r;
  logic [YEAR_W-1:0]    y_r;
  logic [MOD25_W-1:0]   mod25_r;
  logic [MONTH_W-1:0]   m_r;
  logic                 leap_r;
  logic [HOUR_W-1:0]    hour_r;
  logic [MIN_W-1:0]     min_r;
  logic [SEC_W-1:0]     sec_r;

  logic                 out_valid_r;
  logic [SECS_W-1:0]    out_secs_r;
  logic [YEAR_W-1:0]    out_year_r;
  logic [MONTH_W-1:0]   out_month_r;
  logic [DAY_W-1:0]     out_day_r;
  logic [HOUR_W-1:0]    out_hour_r;
  logic [MIN_W-1:0]     out_min_r;
  logic [SEC_W-1:0]     out_sec_r;

  logic [SECS_W-1:0]    alu_a;
  logic [SECS_W-1:0]    alu_b;
  logic                 alu_sub;
  logic [SECS_W-1:0]    alu_res;
  logic                 alu_carry;
  logic                 cur_leap;
  logic [YLEN_W-1:0]    ylen;
  logic [DAY_W-1:0]     mdays;
  logic [SECS_W-1:0]    mul_x;
  logic [RCP_W-1:0]     mul_k;
  logic [MUL_W-1:0]     mul_full;
  logic                 in_fire;
  logic                 out_free;

  ucc_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_res),
    .carry  (alu_carry)
  );

  assign in_fire   = in_ch.valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cur_leap  = is_leap(y_r[3:0], mod25_r);
  assign ylen      = cur_leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
  assign mdays     = month_days(m_r, leap_r);
  assign mul_full  = MUL_W'(mul_x) * MUL_W'(mul_k);

  always_comb begin
    unique case (state_r)
      ST_D_QYR: begin
        mul_x = SECS_W'(year_in_r);
        mul_k = YEAR_RECIP;
      end
      ST_D_PYR: begin
        mul_x = num_r;
        mul_k = LEAP_DIVISOR;
      end
      ST_D_MULDAY: begin
        mul_x = acc_r;
        mul_k = RCP_W'(SECS_PER_DAY);
      end
      ST_D_MULHR: begin
        mul_x = SECS_W'(hour_in_r);
        mul_k = RCP_W'(SECS_PER_HOUR);
      end
      ST_D_MULMIN: begin
        mul_x = SECS_W'(min_in_r);
        mul_k = RCP_W'(SECS_PER_MIN);
      end
      ST_S_QDAY: begin
        mul_x = SECS_W'(num_r[SECS_W-1:DAY_PRE]);
        mul_k = DAY_RECIP;
      end
      ST_S_PDAY: begin
        mul_x = acc_r;
        mul_k = RCP_W'(SECS_PER_DAY);
      end
      ST_S_QHR: begin
        mul_x = SECS_W'(rem_r[REM_W-1:HOUR_PRE]);
        mul_k = HOUR_RECIP;
      end
      ST_S_PHR: begin
        mul_x = SECS_W'(hour_r);
        mul_k = RCP_W'(SECS_PER_HOUR);
      end
      ST_S_QMIN: begin
        mul_x = SECS_W'(rem_r[REM_W-1:MIN_PRE]);
        mul_k = MIN_RECIP;
      end
      ST_S_PMIN: begin
        mul_x = SECS_W'(min_r);
        mul_k = RCP_W'(SECS_PER_MIN);
      end
      default: begin
        mul_x = '0;
        mul_k = '0;
      end
    endcase
  end

  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_D_RYR: begin
        alu_a   = SECS_W'(year_in_r);
        alu_b   = prod_r;
        alu_sub = 1'b1;
      end
      ST_S_RDAY: begin
        alu_a   = num_r;
        alu_b   = prod_r;
        alu_sub = 1'b1;
      end
      ST_S_RHR, ST_S_RMIN: begin
        alu_a   = SECS_W'(rem_r);
        alu_b   = prod_r;
        alu_sub = 1'b1;
      end
      ST_D_YEAR: alu_b = SECS_W'(ylen);
      ST_S_YEAR: begin
        alu_b   = SECS_W'(ylen);
        alu_sub = 1'b1;
      end
      ST_D_MONTH: alu_b = SECS_W'(mdays);
      ST_S_MONTH: begin
        alu_b   = SECS_W'(mdays);
        alu_sub = 1'b1;
      end
      ST_D_DAY: alu_b = SECS_W'(day_in_r);
      ST_D_DAYM1: begin
        alu_b   = SECS_W'(1);
        alu_sub = 1'b1;
      end
      ST_D_ADDHR, ST_D_ADDMIN: alu_b = prod_r;
      ST_D_ADDSEC: alu_b = SECS_W'(sec_in_r);
      default: begin
        alu_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r       <= op_t'(in_ch.operation);
            year_in_r  <= in_ch.in_year;
            month_in_r <= in_ch.in_month;
            day_in_r   <= in_ch.in_day;
            hour_in_r  <= in_ch.in_hour;
            min_in_r   <= in_ch.in_minute;
            sec_in_r   <= in_ch.in_second;
            acc_r      <= '0;
            y_r        <= EPOCH_YEAR;
            mod25_r    <= EPOCH_MOD25;
            m_r        <= MONTH_FIRST;
            if (op_t'(in_ch.operation) == OP_SECS_TO_DATE) begin
              num_r   <= in_ch.in_epoch_seconds;
              state_r <= ST_S_QDAY;
            end else begin
              state_r <= ST_D_QYR;
            end
          end
        end
        ST_D_QYR: begin
          num_r   <= mul_full[YEAR_SHIFT +: SECS_W];
          state_r <= ST_D_PYR;
        end
        ST_D_PYR: begin
          prod_r  <= mul_full[SECS_W-1:0];
          state_r <= ST_D_RYR;
        end
        ST_D_RYR: begin
          leap_r  <= is_leap(year_in_r[3:0], alu_res[MOD25_W-1:0]);
          state_r <= ST_D_YEAR;
        end
        ST_D_YEAR: begin
          if (y_r < year_in_r) begin
            acc_r   <= alu_res;
            y_r     <= y_r + YEAR_W'(1);
            mod25_r <= (mod25_r == MOD25_LAST) ? '0 : mod25_r + MOD25_W'(1);
          end else begin
            state_r <= ST_D_MONTH;
          end
        end
        ST_D_MONTH: begin
          if (m_r < month_in_r) begin
            acc_r <= alu_res;
            m_r   <= m_r + MONTH_W'(1);
          end else begin
            state_r <= ST_D_DAY;
          end
        end
        ST_D_DAY: begin
          acc_r   <= alu_res;
          state_r <= ST_D_DAYM1;
        end
        ST_D_DAYM1: begin
          acc_r   <= alu_res;
          state_r <= ST_D_MULDAY;
        end
        ST_D_MULDAY: begin
          acc_r   <= mul_full[SECS_W-1:0];
          state_r <= ST_D_MULHR;
        end
        ST_D_MULHR: begin
          prod_r  <= mul_full[SECS_W-1:0];
          state_r <= ST_D_ADDHR;
        end
        ST_D_ADDHR: begin
          acc_r   <= alu_res;
          state_r <= ST_D_MULMIN;
        end
        ST_D_MULMIN: begin
          prod_r  <= mul_full[SECS_W-1:0];
          state_r <= ST_D_ADDMIN;
        end
        ST_D_ADDMIN: begin
          acc_r   <= alu_res;
          state_r <= ST_D_ADDSEC;
        end
        ST_D_ADDSEC: begin
          acc_r   <= alu_res;
          state_r <= ST_FIN;
        end
        ST_S_QDAY: begin
          acc_r   <= SECS_W'(mul_full[MUL_W-1:DAY_SHIFT]);
          state_r <= ST_S_PDAY;
        end
        ST_S_PDAY: begin
          prod_r  <= mul_full[SECS_W-1:0];
          state_r <= ST_S_RDAY;
        end
        ST_S_RDAY: begin
          rem_r   <= alu_res[REM_W-1:0];
          state_r <= ST_S_QHR;
        end
        ST_S_QHR: begin
          hour_r  <= mul_full[HOUR_SHIFT +: HOUR_W];
          state_r <= ST_S_PHR;
        end
        ST_S_PHR: begin
          prod_r  <= mul_full[SECS_W-1:0];
          state_r <= ST_S_RHR;
        end
        ST_S_RHR: begin
          rem_r   <= alu_res[REM_W-1:0];
          state_r <= ST_S_QMIN;
        end
        ST_S_QMIN: begin
          min_r   <= mul_full[MIN_SHIFT +: MIN_W];
          state_r <= ST_S_PMIN;
        end
        ST_S_PMIN: begin
          prod_r  <= mul_full[SECS_W-1:0];
          state_r <= ST_S_RMIN;
        end
        ST_S_RMIN: begin
          sec_r   <= alu_res[SEC_W-1:0];
          state_r <= ST_S_YEAR;
        end
        ST_S_YEAR: begin
          if (alu_carry) begin
            acc_r   <= alu_res;
            y_r     <= y_r + YEAR_W'(1);
            mod25_r <= (mod25_r == MOD25_LAST) ? '0 : mod25_r + MOD25_W'(1);
          end else begin
            leap_r  <= cur_leap;
            state_r <= ST_S_MONTH;
          end
        end
        ST_S_MONTH: begin
          if ((m_r <= MONTH_LAST) && alu_carry) begin
            acc_r <= alu_res;
            m_r   <= m_r + MONTH_W'(1);
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (op_r == OP_SECS_TO_DATE) begin
              out_secs_r  <= '0;
              out_year_r  <= y_r;
              out_month_r <= m_r;
              out_day_r   <= acc_r[DAY_W-1:0] + DAY_W'(1);
              out_hour_r  <= hour_r;
              out_min_r   <= min_r;
              out_sec_r   <= sec_r;
            end else begin
              out_secs_r  <= acc_r;
              out_year_r  <= '0;
              out_month_r <= '0;
              out_day_r   <= '0;
              out_hour_r  <= '0;
              out_min_r   <= '0;
              out_sec_r   <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.out_epoch_seconds = out_secs_r;
  assign out_ch.out_year          = out_year_r;
  assign out_ch.out_month         = out_month_r;
  assign out_ch.out_day           = out_day_r;
  assign out_ch.out_hour          = out_hour_r;
  assign out_ch.out_minute        = out_min_r;
  assign out_ch.out_second        = out_sec_r;
endmodule

@@ rtl/ucc_checker.sv @@
// Port-level assertions for the Unix time and calendar converter.
// Watches the top level's channels and is bound to it at the end of this file.
module ucc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ucc_pkg::SECS_W-1:0] out_epoch_seconds,
  input logic [ucc_pkg::YEAR_W-1:0] out_year,
  input logic [ucc_pkg::MONTH_W-1:0] out_month
);
  import ucc_pkg::*;

  // The block works on one item at a time, so it drops ready after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an item was accepted");

  // A new result only appears at the end of an item's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in progress");

  // Each result carries either seconds or a date, never both.
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_epoch_seconds == '0) || ((out_year == '0) && (out_month == '0)))
    else $error("result carries both seconds and a date");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_epoch_seconds) && $stable(out_year))
    else $error("stalled result changed or was dropped");
endmodule

bind unix_time_calendar_converter ucc_checker u_ucc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_epoch_seconds (out_ch.out_epoch_seconds),
  .out_year          (out_ch.out_year),
  .out_month         (out_ch.out_month)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for unix_time_calendar_converter, both conversion directions.
// Needs ucc_pkg, ucc_in_if, ucc_out_if and the converter RTL; a local calendar
// predictor checks every result item in order.
module tb_top;
  import ucc_pkg::*;

  typedef struct packed {
    op_t               op;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [SECS_W-1:0] secs;
  } conversion_t;

  typedef struct packed {
    logic [SECS_W-1:0]  secs;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } calendar_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ucc_in_if  in_ch ();
  ucc_out_if out_ch ();

  unix_time_calendar_converter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  conversion_t      pending_conversions[$];
  calendar_result_t expected_results[$];
  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_taken = 1'b0;
  bit  hold_recv = 1'b0;
  bit  long_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned days_in_year(int unsigned y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    return leap ? 366 : 365;
  endfunction

  function automatic int unsigned month_span(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return (days_in_year(y) == 366) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic calendar_result_t predict_conversion(conversion_t c);
    calendar_result_t r;
    longint unsigned  days;
    longint unsigned  total;
    int unsigned      y;
    int unsigned      m;
    int unsigned      rem;
    int unsigned      day_count;
    int unsigned      day_term;
    r = '0;
    if (c.op == OP_DATE_TO_SECS) begin
      days = 0;
      for (y = 1970; y < c.year; y++) days += days_in_year(y);
      for (m = 1; m < c.month; m++) days += month_span(c.year, m);
      day_term = {27'd0, c.day} - 32'd1;
      days = (days + day_term) & 64'hFFFF_FFFF;
      total = days * 86400 + c.hour * 3600 + c.minute * 60 + c.second;
      r.secs = total[31:0];
    end else begin
      day_count = c.secs / 86400;
      rem = c.secs % 86400;
      r.hour = HOUR_W'(rem / 3600);
      rem = rem % 3600;
      r.minute = MIN_W'(rem / 60);
      r.second = SEC_W'(rem % 60);
      y = 1970;
      while (day_count >= days_in_year(y)) begin
        day_count -= days_in_year(y);
        y++;
      end
      m = 1;
      while (m <= 12 && day_count >= month_span(y, m)) begin
        day_count -= month_span(y, m);
        m++;
      end
      r.year = YEAR_W'(y);
      r.month = MONTH_W'(m);
      r.day = DAY_W'(day_count + 1);
    end
    return r;
  endfunction

  function automatic conversion_t date_item(int unsigned y, int unsigned mo, int unsigned d,
                                            int unsigned h, int unsigned mi, int unsigned s);
    conversion_t c;
    c.op = OP_DATE_TO_SECS;
    c.year = YEAR_W'(y);
    c.month = MONTH_W'(mo);
    c.day = DAY_W'(d);
    c.hour = HOUR_W'(h);
    c.minute = MIN_W'(mi);
    c.second = SEC_W'(s);
    c.secs = $urandom;
    return c;
  endfunction

  function automatic conversion_t secs_item(logic [SECS_W-1:0] s);
    conversion_t c;
    c = date_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    c.op = OP_SECS_TO_DATE;
    c.secs = s;
    return c;
  endfunction

  // Years past 2106 lengthen the block's year walk, so they stay rare.
  function automatic conversion_t random_conversion();
    conversion_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    c.year = (pick < 92) ? YEAR_W'($urandom_range(2106, 1970)) :
             (pick < 96) ? YEAR_W'($urandom_range(1969, 0)) :
                           YEAR_W'($urandom_range(4095, 2107));
    c.month = ($urandom_range(99) < 90) ? MONTH_W'($urandom_range(12, 1)) : MONTH_W'($urandom);
    c.day = ($urandom_range(99) < 88) ? DAY_W'($urandom_range(31, 1)) : DAY_W'($urandom);
    c.hour = ($urandom_range(99) < 90) ? HOUR_W'($urandom_range(23, 0)) : HOUR_W'($urandom);
    c.minute = ($urandom_range(99) < 90) ? MIN_W'($urandom_range(59, 0)) : MIN_W'($urandom);
    c.second = ($urandom_range(99) < 90) ? SEC_W'($urandom_range(59, 0)) : SEC_W'($urandom);
    pick = $urandom_range(99);
    c.secs = (pick < 60) ? $urandom :
             (pick < 75) ? 32'hFFFF_FFFF - $urandom_range(200000, 0) :
             (pick < 87) ? $urandom_range(86400 * 400, 0) :
                           $urandom_range(49710, 0) * 86400 + $urandom_range(1, 0);
    c.op = op_t'($urandom_range(1));
    return c;
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin : drive_items
    conversion_t next;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_conversions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next = pending_conversions.pop_front();
        in_ch.operation <= next.op;
        in_ch.in_year <= next.year;
        in_ch.in_month <= next.month;
        in_ch.in_day <= next.day;
        in_ch.in_hour <= next.hour;
        in_ch.in_minute <= next.minute;
        in_ch.in_second <= next.second;
        in_ch.in_epoch_seconds <= next.secs;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : watch_channels
    conversion_t      seen;
    calendar_result_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result item with none expected, actual secs %0d date %0d-%0d-%0d",
                 $time, out_ch.out_epoch_seconds, out_ch.out_year, out_ch.out_month,
                 out_ch.out_day);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("out_epoch_seconds", want.secs, out_ch.out_epoch_seconds);
        check_field("out_year", want.year, out_ch.out_year);
        check_field("out_month", want.month, out_ch.out_month);
        check_field("out_day", want.day, out_ch.out_day);
        check_field("out_hour", want.hour, out_ch.out_hour);
        check_field("out_minute", want.minute, out_ch.out_minute);
        check_field("out_second", want.second, out_ch.out_second);
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.op = op_t'(in_ch.operation);
      seen.year = in_ch.in_year;
      seen.month = in_ch.in_month;
      seen.day = in_ch.in_day;
      seen.hour = in_ch.in_hour;
      seen.minute = in_ch.in_minute;
      seen.second = in_ch.in_second;
      seen.secs = in_ch.in_epoch_seconds;
      expected_results.push_back(predict_conversion(seen));
    end
  end

  // The result side stays blocked long enough for the converter to fill up.
  initial begin
    while (!long_hold_req) @(posedge clk);
    hold_recv = 1'b1;
    repeat (1200) @(posedge clk);
    hold_recv = 1'b0;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic settle_converter();
    do @(negedge clk);
    while (pending_conversions.size() != 0 || in_ch.valid || expected_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) pending_conversions.push_back(random_conversion());
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_DATE_TO_SECS;
    in_ch.in_year = '0;
    in_ch.in_month = '0;
    in_ch.in_day = '0;
    in_ch.in_hour = '0;
    in_ch.in_minute = '0;
    in_ch.in_second = '0;
    in_ch.in_epoch_seconds = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_conversions.push_back(date_item(1970, 1, 1, 0, 0, 0));
    pending_conversions.push_back(date_item(2106, 2, 7, 6, 28, 15));
    pending_conversions.push_back(date_item(2106, 12, 31, 23, 59, 59));
    pending_conversions.push_back(date_item(2000, 2, 29, 12, 0, 0));
    pending_conversions.push_back(date_item(2100, 3, 1, 0, 0, 0));
    pending_conversions.push_back(date_item(1972, 2, 29, 23, 59, 59));
    pending_conversions.push_back(date_item(0, 6, 15, 1, 2, 3));
    pending_conversions.push_back(date_item(1980, 0, 10, 4, 5, 6));
    pending_conversions.push_back(date_item(1990, 13, 1, 0, 0, 0));
    pending_conversions.push_back(date_item(2024, 15, 31, 31, 63, 63));
    pending_conversions.push_back(date_item(2020, 5, 0, 0, 0, 0));
    pending_conversions.push_back(date_item(1970, 1, 0, 0, 0, 0));
    pending_conversions.push_back(date_item(0, 0, 0, 0, 0, 0));
    pending_conversions.push_back(date_item(4095, 15, 31, 31, 63, 63));
    pending_conversions.push_back(secs_item(32'd0));
    pending_conversions.push_back(secs_item(32'hFFFF_FFFF));
    pending_conversions.push_back(secs_item(32'd86399));
    pending_conversions.push_back(secs_item(32'd86400));
    pending_conversions.push_back(secs_item(32'd31535999));
    pending_conversions.push_back(secs_item(32'd68169600));
    pending_conversions.push_back(secs_item(32'd951782400));
    pending_conversions.push_back(secs_item(32'd951868800));
    pending_conversions.push_back(secs_item(32'd4107456000));
    settle_converter();

    send_idle_pct = 8;
    recv_idle_pct = 67;
    queue_random(510);
    settle_converter();

    send_idle_pct = 67;
    recv_idle_pct = 8;
    queue_random(510);
    settle_converter();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    queue_random(510);
    settle_converter();

    repeat (250) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ucc_pkg.sv
rtl/ucc_in_if.sv
rtl/ucc_out_if.sv
rtl/ucc_alu.sv
rtl/unix_time_calendar_converter.sv
rtl/ucc_checker.sv
verif/tb_top.sv
